// ===== rtl/mavlink2_frame_encoder_top_assert.svh =====
// Assertion macros used by the frame encoder top level.
`ifndef MAVLINK2_FRAME_ENCODER_TOP_ASSERT_SVH
`define MAVLINK2_FRAME_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MV2_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mv2enc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MV2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mv2enc: next-cycle check failed");

`endif

// ===== rtl/mv2enc_pkg.sv =====
// Shared types, constants and the X.25 CRC step for the frame encoder.
package mv2enc_pkg;

    // Input item kinds (carried on tuser)
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Protocol constants
    localparam logic [7:0]  MAGIC       = 8'hFD;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  SYS_ID_RST  = 8'd245;
    localparam logic [7:0]  COMP_ID_RST = 8'd190;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_KNOWN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_ID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_ID = 2'd2;

    // Byte positions of the serializer
    localparam logic [3:0] STEP_MAGIC    = 4'd0;
    localparam logic [3:0] STEP_LEN      = 4'd1;
    localparam logic [3:0] STEP_INCOMPAT = 4'd2;
    localparam logic [3:0] STEP_COMPAT   = 4'd3;
    localparam logic [3:0] STEP_SEQ      = 4'd4;
    localparam logic [3:0] STEP_SYSID    = 4'd5;
    localparam logic [3:0] STEP_COMPID   = 4'd6;
    localparam logic [3:0] STEP_MSGID0   = 4'd7;
    localparam logic [3:0] STEP_MSGID1   = 4'd8;
    localparam logic [3:0] STEP_MSGID2   = 4'd9;
    localparam logic [3:0] STEP_CRC_LO   = 4'd10;
    localparam logic [3:0] STEP_CRC_HI   = 4'd11;

    // One unit of output work handed from the control stage to the serializer.
    // A payload job puts its byte in msg_id[23:16] and starts at STEP_MSGID2.
    typedef struct packed {
        logic        valid;
        logic        is_payload;
        logic        close;       // append the two CRC bytes
        logic [7:0]  len;
        logic [7:0]  seq;
        logic [7:0]  sys_id;
        logic [7:0]  comp_id;
        logic [23:0] msg_id;
        logic [7:0]  extra;
    } job_t;

    // One byte of the X.25 (MCRF4XX) CRC
    function automatic logic [15:0] x25_step(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ c[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, c[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ===== rtl/mv2enc_ctl.sv =====
// Frame control: sequence, payload count and drop state; turns items into jobs.
module mv2enc_ctl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               peer_known,
    input  logic [7:0]         system_id,
    input  logic [7:0]         component_id,
    input  logic               job_take,
    output mv2enc_pkg::job_t   job
);

    logic [7:0]       sequence_reg, sequence_next;
    logic [7:0]       bytes_left_reg, bytes_left_next;
    logic [7:0]       held_extra_reg, held_extra_next;
    logic             in_frame_reg, in_frame_next;
    logic             dropping_reg, dropping_next;
    mv2enc_pkg::job_t job_reg, job_next;

    logic        accept;
    logic [23:0] in_msg_id;
    logic [7:0]  in_len;
    logic [7:0]  in_extra;
    logic [7:0]  in_byte;
    logic [7:0]  left_dec;

    assign in_msg_id = s_tdata[23:0];
    assign in_len    = s_tdata[31:24];
    assign in_extra  = s_tdata[39:32];
    assign in_byte   = s_tdata[47:40];
    assign left_dec  = bytes_left_reg - 8'd1;

    // Job slot frees when empty or being taken by the serializer
    assign s_tready = !job_reg.valid || job_take;
    assign accept   = s_tvalid && s_tready;
    assign job      = job_reg;

    // Item decode and state update
    always_comb
    begin
        sequence_next   = sequence_reg;
        bytes_left_next = bytes_left_reg;
        held_extra_next = held_extra_reg;
        in_frame_next   = in_frame_reg;
        dropping_next   = dropping_reg;
        job_next        = job_reg;
        if (job_take)
        begin
            job_next.valid = 1'b0;
        end
        if (accept)
        begin
            if (s_tuser == mv2enc_pkg::OP_HEADER)
            begin
                in_frame_next   = 1'b1;
                bytes_left_next = in_len;
                held_extra_next = in_extra;
                if (!peer_known)
                begin
                    dropping_next = 1'b1;
                    if (in_len == 8'd0)
                    begin
                        in_frame_next = 1'b0;
                    end
                end
                else
                begin
                    dropping_next       = 1'b0;
                    sequence_next       = sequence_reg + 8'd1;
                    job_next.valid      = 1'b1;
                    job_next.is_payload = 1'b0;
                    job_next.close      = (in_len == 8'd0);
                    job_next.len        = in_len;
                    job_next.seq        = sequence_reg;
                    job_next.sys_id     = system_id;
                    job_next.comp_id    = component_id;
                    job_next.msg_id     = in_msg_id;
                    job_next.extra      = in_extra;
                    if (in_len == 8'd0)
                    begin
                        in_frame_next = 1'b0;
                    end
                end
            end
            else if (in_frame_reg && (bytes_left_reg != 8'd0))
            begin
                bytes_left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    in_frame_next = 1'b0;
                end
                if (!dropping_reg)
                begin
                    job_next.valid       = 1'b1;
                    job_next.is_payload  = 1'b1;
                    job_next.close       = (left_dec == 8'd0);
                    job_next.msg_id      = {in_byte, 16'h0000};
                    job_next.extra       = held_extra_reg;
                end
            end
        end
    end

    // State registers and job slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sequence_reg   <= 8'd0;
            bytes_left_reg <= 8'd0;
            held_extra_reg <= 8'd0;
            in_frame_reg   <= 1'b0;
            dropping_reg   <= 1'b0;
            job_reg        <= '0;
        end
        else
        begin
            sequence_reg   <= sequence_next;
            bytes_left_reg <= bytes_left_next;
            held_extra_reg <= held_extra_next;
            in_frame_reg   <= in_frame_next;
            dropping_reg   <= dropping_next;
            job_reg        <= job_next;
        end
    end

endmodule

// ===== rtl/mv2enc_ser.sv =====
// Byte serializer: emits header, payload and CRC bytes, one per transaction.
module mv2enc_ser (
    input  logic             clk,
    input  logic             rst_n,
    input  mv2enc_pkg::job_t job,
    output logic             job_take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // frame_end
);

    logic             busy_reg, busy_next;
    logic [3:0]       step_reg, step_next;
    logic [15:0]      crc_reg, crc_next;
    mv2enc_pkg::job_t cur_reg;

    logic        advance;
    logic        last_byte;
    logic        in_crc;
    logic [7:0]  data_byte;
    logic [7:0]  crc_in;
    logic [15:0] crc_fold;

    assign advance   = busy_reg && m_tready;
    assign last_byte = (step_reg == mv2enc_pkg::STEP_CRC_HI) ||
                       ((step_reg == mv2enc_pkg::STEP_MSGID2) && !cur_reg.close);
    assign job_take  = job.valid && (!busy_reg || (advance && last_byte));

    // Frame byte select
    always_comb
    begin
        in_crc = 1'b1;
        case (step_reg)
            mv2enc_pkg::STEP_MAGIC:
            begin
                data_byte = mv2enc_pkg::MAGIC;
                in_crc    = 1'b0;
            end
            mv2enc_pkg::STEP_LEN:    data_byte = cur_reg.len;
            mv2enc_pkg::STEP_SEQ:    data_byte = cur_reg.seq;
            mv2enc_pkg::STEP_SYSID:  data_byte = cur_reg.sys_id;
            mv2enc_pkg::STEP_COMPID: data_byte = cur_reg.comp_id;
            mv2enc_pkg::STEP_MSGID0: data_byte = cur_reg.msg_id[7:0];
            mv2enc_pkg::STEP_MSGID1: data_byte = cur_reg.msg_id[15:8];
            mv2enc_pkg::STEP_MSGID2: data_byte = cur_reg.msg_id[23:16];
            default:                 data_byte = 8'h00;   // flag bytes
        endcase
        if ((step_reg == mv2enc_pkg::STEP_CRC_LO) || (step_reg == mv2enc_pkg::STEP_CRC_HI))
        begin
            in_crc = 1'b0;
        end
    end

    // One CRC unit: frame bytes, then the extra byte at the low CRC position
    assign crc_in   = (step_reg == mv2enc_pkg::STEP_CRC_LO) ? cur_reg.extra : data_byte;
    assign crc_fold = mv2enc_pkg::x25_step(crc_reg, crc_in);

    always_comb
    begin
        case (step_reg)
            mv2enc_pkg::STEP_CRC_LO: m_tdata = crc_fold[7:0];
            mv2enc_pkg::STEP_CRC_HI: m_tdata = crc_reg[15:8];
            default:                 m_tdata = data_byte;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = busy_reg && (step_reg == mv2enc_pkg::STEP_CRC_HI);

    // Sequencing
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        crc_next  = crc_reg;
        if (advance)
        begin
            if (in_crc || (step_reg == mv2enc_pkg::STEP_CRC_LO))
            begin
                crc_next = crc_fold;
            end
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
        if (job_take)
        begin
            busy_next = 1'b1;
            if (job.is_payload)
            begin
                step_next = mv2enc_pkg::STEP_MSGID2;
            end
            else
            begin
                step_next = mv2enc_pkg::STEP_MAGIC;
                crc_next  = mv2enc_pkg::CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= mv2enc_pkg::STEP_MAGIC;
            crc_reg  <= mv2enc_pkg::CRC_INIT;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            crc_reg  <= crc_next;
        end
    end

    // Current job, no reset
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            cur_reg <= job;
        end
    end

endmodule

// ===== rtl/mavlink2_frame_encoder_top.sv =====
// Top level of the MAVLink v2 frame encoder: config registers, control and serializer.
//
// Usage:
//   Input stream (s_*): tuser = 0 is a header item (message id, length, extra byte),
//   tuser = 1 carries one payload byte. Output stream (m_*): one frame byte per
//   transaction, tlast marks the high CRC byte that ends a frame.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 peer_known,
//   1 system_id, 2 component_id) at the clock edge; write only while idle.
// Flow and throughput:
//   With the serializer free, an item is registered in the job slot, then taken into
//   the serializer, which then drives its first byte. A header emits ten bytes (twelve
//   when length is 0); a payload byte emits one (three for the last one, with the CRC).
//   Payload bytes pass at one per cycle while m_tready is high and items keep coming.
//   Dropped frames and stray payload bytes are accepted and produce no output.
// Reset: rst_n clears all state but the serializer's current job; sequence 0,
//   peer_known 0, system_id 245, component_id 190.
// Stalls: with m_tready low the current byte holds; one more item is buffered in
//   the job slot, then s_tready drops until the serializer frees it.
module mavlink2_frame_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [23:0] message_id, [31:24] length,
                                    // [39:32] msg_extra, [47:40] payload_byte
    input  logic        s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // frame_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

`include "mavlink2_frame_encoder_top_assert.svh"

    logic             peer_known_reg;
    logic [7:0]       system_id_reg;
    logic [7:0]       component_id_reg;
    logic             job_take;
    mv2enc_pkg::job_t job;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_known_reg   <= 1'b0;
            system_id_reg    <= mv2enc_pkg::SYS_ID_RST;
            component_id_reg <= mv2enc_pkg::COMP_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mv2enc_pkg::REG_PEER_KNOWN:   peer_known_reg   <= cfg_data[0];
                mv2enc_pkg::REG_SYSTEM_ID:    system_id_reg    <= cfg_data;
                mv2enc_pkg::REG_COMPONENT_ID: component_id_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mv2enc_ctl u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .peer_known   (peer_known_reg),
        .system_id    (system_id_reg),
        .component_id (component_id_reg),
        .job_take     (job_take),
        .job          (job)
    );

    mv2enc_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .job_take (job_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A pending job never waits on an idle serializer
    `MV2_ASSERT_NEXT(a_job_loads, job.valid && !m_tvalid, m_tvalid)
    // Input backpressure only when both the slot and the serializer are full
    `MV2_ASSERT_NOW(a_ready_cause, !s_tready, job.valid && m_tvalid)
    // A header with the peer unknown yields no job
    `MV2_ASSERT_NEXT(a_drop_header,
        s_tvalid && s_tready && (s_tuser == mv2enc_pkg::OP_HEADER) && !peer_known_reg,
        !job.valid)

endmodule
